// ===== rtl/fpc_pkg.sv =====
// ---------------------------------------------------------------------------
// fpc_pkg: shared types and constants of the fragmented packet checker
// Beat payload structs, result codes, configuration register indexes and resets.
// ---------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

  // Header byte fields
  localparam logic [7:0] START_BIT = 8'h80;
  localparam logic [7:0] SEQ_MASK  = 8'h1f;

  // Configuration register indexes
  localparam logic [1:0] CFG_SINGLE_LIMIT = 2'd0;
  localparam logic [1:0] CFG_START_MARK   = 2'd1;
  localparam logic [1:0] CFG_FIRST_CODE   = 2'd2;

  // Configuration reset values
  localparam logic [7:0] RST_SINGLE_LIMIT = 8'd17;
  localparam logic [7:0] RST_START_MARK   = 8'd0;
  localparam logic [7:0] RST_FIRST_CODE   = 8'd161;

  // Required high offset bits; accepted command codes span eight consecutive values
  localparam logic [4:0] CMD_SPAN_HI = 5'd0;  // code offset bits 7..3 must be zero

  // Command indexes that act on the pause flag
  localparam logic [2:0] CMD_IDX_RESUME_A = 3'd0;
  localparam logic [2:0] CMD_IDX_RESUME_B = 3'd2;
  localparam logic [2:0] CMD_IDX_PAUSE    = 3'd3;

  typedef enum logic [1:0] {
    ST_ACCEPTED    = 2'd0,
    ST_CHECK_ERR   = 2'd1,
    ST_HEADER_ERR  = 2'd2,
    ST_UNKNOWN_CMD = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       fragment_end;
  } item_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] command_index;
    logic [7:0] command_code;
    logic [4:0] sequence_number;
    logic       upload_paused;
  } result_t;

  typedef struct packed {
    logic [7:0] single_fragment_limit;
    logic [7:0] host_start_mark;
    logic [7:0] first_command_code;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/fpc_input_reg.sv =====
// ---------------------------------------------------------------------------
// fpc_input_reg: input beat register
// Captures one byte beat per cycle; holds it while the core cannot take it.
// ---------------------------------------------------------------------------
`default_nettype none

module fpc_input_reg
  import fpc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire item_t in_item,
  output logic       item_valid,
  output item_t      item,
  input  wire logic  item_ready
);

  logic full;

  // Hold the beat while the core refuses it
  assign in_stall   = full && !item_ready;
  assign item_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!in_stall) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fpc_core.sv =====
// ---------------------------------------------------------------------------
// fpc_core: packet state and result register
// Tracks header, byte count and running XOR; registers one result per packet.
// ---------------------------------------------------------------------------
`default_nettype none

module fpc_core
  import fpc_pkg::*;
#(
  parameter int HEADER_POS  = 0,
  parameter int LENGTH_POS  = 1,
  parameter int COMMAND_POS = 2
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire logic    item_valid,
  input  wire item_t   item,
  output logic         item_ready,
  output logic         res_valid,
  output result_t      res,
  input  wire logic    res_stall
);

  localparam logic [7:0] HDR_POS = 8'(HEADER_POS);
  localparam logic [7:0] LEN_POS = 8'(LENGTH_POS);
  localparam logic [7:0] CMD_POS = 8'(COMMAND_POS);

  logic       multi_mode, multi_mode_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] running_check, running_check_next;
  logic       header_mark, header_mark_next;
  logic [4:0] packet_sequence, packet_sequence_next;
  logic [7:0] declared_length, declared_length_next;
  logic [7:0] packet_command, packet_command_next;
  logic       pause_flag, pause_flag_next;

  logic       take;
  logic       finish;
  logic [7:0] check_upd;
  logic [7:0] count_inc;
  logic [7:0] seq_byte;
  logic [8:0] code_diff;
  logic [7:0] mark_seen;
  result_t    res_next;

  // Advance when the result slot is free or drains this cycle
  assign item_ready = !res_valid || !res_stall;
  assign take       = item_valid && item_ready;

  always_comb begin
    header_mark_next     = header_mark;
    packet_sequence_next = packet_sequence;
    declared_length_next = declared_length;
    packet_command_next  = packet_command;
    seq_byte             = item.data_byte & SEQ_MASK;

    if (!multi_mode) begin
      if (byte_count == 8'd0) begin
        header_mark_next     = 1'b0;
        packet_sequence_next = 5'd0;
        declared_length_next = 8'd0;
        packet_command_next  = 8'd0;
      end
      if (byte_count == HDR_POS) begin
        header_mark_next     = |(item.data_byte & START_BIT);
        packet_sequence_next = seq_byte[4:0];
      end
      if (byte_count == LEN_POS) begin
        declared_length_next = item.data_byte;
      end
      if (byte_count == CMD_POS) begin
        packet_command_next = item.data_byte;
      end
    end

    check_upd = running_check ^ item.data_byte;
    count_inc = (byte_count == 8'hff) ? byte_count : byte_count + 8'd1;

    finish = 1'b0;
    multi_mode_next = multi_mode;
    if (item.fragment_end) begin
      if (!multi_mode) begin
        finish = declared_length_next < cfg.single_fragment_limit;
        multi_mode_next = !finish;
      end else begin
        finish = count_inc > declared_length_next;
      end
    end

    code_diff = {1'b0, packet_command_next} - {1'b0, cfg.first_command_code};
    mark_seen = header_mark_next ? START_BIT : 8'h00;

    pause_flag_next        = pause_flag;
    res_next.command_index = 3'd0;
    if (check_upd != 8'd0) begin
      res_next.status = ST_CHECK_ERR;
    end else if (mark_seen != cfg.host_start_mark) begin
      res_next.status = ST_HEADER_ERR;
    end else if (!code_diff[8] && code_diff[7:3] == CMD_SPAN_HI) begin
      res_next.status        = ST_ACCEPTED;
      res_next.command_index = code_diff[2:0];
      if (code_diff[2:0] == CMD_IDX_PAUSE) begin
        pause_flag_next = 1'b1;
      end else if (code_diff[2:0] == CMD_IDX_RESUME_A ||
                   code_diff[2:0] == CMD_IDX_RESUME_B) begin
        pause_flag_next = 1'b0;
      end
    end else begin
      res_next.status = ST_UNKNOWN_CMD;
    end
    if (!finish) begin
      pause_flag_next = pause_flag;
    end
    res_next.command_code    = packet_command_next;
    res_next.sequence_number = packet_sequence_next;
    res_next.upload_paused   = pause_flag_next;

    if (finish) begin
      multi_mode_next    = 1'b0;
      byte_count_next    = 8'd0;
      running_check_next = 8'd0;
    end else begin
      byte_count_next    = count_inc;
      running_check_next = check_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      multi_mode      <= 1'b0;
      byte_count      <= 8'd0;
      running_check   <= 8'd0;
      header_mark     <= 1'b0;
      packet_sequence <= 5'd0;
      declared_length <= 8'd0;
      packet_command  <= 8'd0;
      pause_flag      <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      if (take) begin
        multi_mode      <= multi_mode_next;
        byte_count      <= byte_count_next;
        running_check   <= running_check_next;
        header_mark     <= header_mark_next;
        packet_sequence <= packet_sequence_next;
        declared_length <= declared_length_next;
        packet_command  <= packet_command_next;
        pause_flag      <= pause_flag_next;
        res_valid       <= finish;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && finish) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fragmented_packet_checker.sv =====
// ---------------------------------------------------------------------------
// fragmented_packet_checker: radio write fragment reassembly and check
//
// Input channel (in_valid / in_stall): one beat per received byte, with
// fragment_end marking the last byte of a radio write fragment. The first
// fragment of a packet carries the header (start mark and sequence number,
// declared length, command code). A packet ends with its first fragment when
// the declared length is below single_fragment_limit, else at the first later
// fragment end where the byte count exceeds the declared length.
// Output channel (out_valid / out_stall): one beat per finished packet with
// status, command index and code, sequence number and the pause flag.
// Config channel (cfg_valid / cfg_ready): always ready; write only while idle.
// Throughput: one byte beat per cycle while no result is stalled. The last
// byte passes the input register, then the result register holds its result.
// Reset clears the packet state, pause flag and both channel registers, and
// loads the configuration defaults. While out_stall holds a result, the
// input register fills and then in_stall rises until the result drains.
// ---------------------------------------------------------------------------
`default_nettype none

module fragmented_packet_checker
  import fpc_pkg::*;
#(
  parameter int HEADER_POS  = 0,
  parameter int LENGTH_POS  = 1,
  parameter int COMMAND_POS = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // byte beats
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       fragment_end,
  // result beats
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      status,
  output logic [2:0]      command_index,
  output logic [7:0]      command_code,
  output logic [4:0]      sequence_number,
  output logic            upload_paused,
  // configuration writes
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    item_ready;
  result_t res;

  // Configuration registers: accept a write every cycle, drop unknown indexes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.single_fragment_limit <= RST_SINGLE_LIMIT;
      cfg.host_start_mark       <= RST_START_MARK;
      cfg.first_command_code    <= RST_FIRST_CODE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SINGLE_LIMIT: cfg.single_fragment_limit <= cfg_data;
        CFG_START_MARK:   cfg.host_start_mark       <= cfg_data;
        CFG_FIRST_CODE:   cfg.first_command_code    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item = {data_byte, fragment_end};

  // Register the incoming byte beat
  fpc_input_reg u_input_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  // Advance packet state and register the result
  fpc_core #(
    .HEADER_POS  (HEADER_POS),
    .LENGTH_POS  (LENGTH_POS),
    .COMMAND_POS (COMMAND_POS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .res_valid  (out_valid),
    .res        (res),
    .res_stall  (out_stall)
  );

  assign status          = res.status;
  assign command_index   = res.command_index;
  assign command_code    = res.command_code;
  assign sequence_number = res.sequence_number;
  assign upload_paused   = res.upload_paused;

  // Input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // Index is zero unless the command was accepted
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_ACCEPTED) |-> (command_index == 3'd0))
    else $error("command_index set on a rejected packet");

  // Pause command leaves the flag set
  a_pause_set: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_ACCEPTED && command_index == CMD_IDX_PAUSE)
      |-> upload_paused)
    else $error("pause command did not set upload_paused");

  // No result right out of reset
  a_reset_idle: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !out_valid)
    else $error("out_valid after reset");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ---------------------------------------------------------------------------
// tb: self-checking bench for fragmented_packet_checker
// A queue-fed driver pushes byte beats while a monitor replays each
// accepted beat through a local packet predictor and checks every result
// beat, field by field, against the oldest predicted result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fpc_pkg::*;

  localparam int HEADER_POS    = 0;
  localparam int LENGTH_POS    = 1;
  localparam int COMMAND_POS   = 2;
  localparam int SETTLE_CYCLES = 6;     // settle time for a trailing packet that yields no result
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off to back up the block
  localparam int QUIET_LIMIT   = 3000;  // cycles with no handshake at all before giving up

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       fragment_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] status;
  logic [2:0] command_index;
  logic [7:0] command_code;
  logic [4:0] sequence_number;
  logic       upload_paused;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_SINGLE_LIMIT;
  logic [7:0] cfg_data = 8'h00;

  fragmented_packet_checker #(
    .HEADER_POS (HEADER_POS),
    .LENGTH_POS (LENGTH_POS),
    .COMMAND_POS(COMMAND_POS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .fragment_end   (fragment_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .command_index  (command_index),
    .command_code   (command_code),
    .sequence_number(sequence_number),
    .upload_paused  (upload_paused),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Byte beats waiting to be sent, and packet results waiting to arrive.
  item_t   byte_beats [$];
  result_t expected_results [$];
  int      beats_queued = 0;

  // Idle odds in percent, set per phase by the sequencer.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Long hold-off request: toggled by the sequencer, served by the receiver.
  bit hold_req  = 1'b0;
  bit hold_ack  = 1'b0;
  int hold_left = 0;

  int      mismatch_count = 0;
  int      quiet_cycles = 0;
  bit      beat_taken = 1'b0;
  bit      result_taken;
  bit      cfg_taken;
  result_t oldest;

  // Shadow of the configuration registers, kept in step with every write.
  cfg_t shadow_cfg = '{single_fragment_limit: RST_SINGLE_LIMIT,
                       host_start_mark:       RST_START_MARK,
                       first_command_code:    RST_FIRST_CODE};

  // Packet predictor state.
  bit         in_multi   = 1'b0;
  logic [7:0] bytes_seen = 8'h00;
  logic [7:0] xor_acc    = 8'h00;
  bit         hdr_start  = 1'b0;
  logic [4:0] hdr_seq    = 5'h00;
  logic [7:0] hdr_length = 8'h00;
  logic [7:0] hdr_code   = 8'h00;
  bit         paused     = 1'b0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("[%0t] %s", $time, msg);
  endtask

  task automatic check_field(input string field, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s mismatch: got %0d, expected %0d", field, got, want));
    end
  endtask

  // Close the packet under assembly: grade it, apply its command to the
  // pause flag and queue the result the block must produce.
  task automatic close_packet();
    result_t    r;
    logic [7:0] first;
    first = shadow_cfg.first_command_code;
    r = '0;
    r.command_code    = hdr_code;
    r.sequence_number = hdr_seq;
    // check first, then start mark, then command code; codes do not wrap
    if (xor_acc != 8'h00) begin
      r.status = ST_CHECK_ERR;
    end else if ((hdr_start ? START_BIT : 8'h00) != shadow_cfg.host_start_mark) begin
      r.status = ST_HEADER_ERR;
    end else if (hdr_code >= first && (hdr_code - first) < 8'd8) begin
      r.status = ST_ACCEPTED;
      r.command_index = 3'(hdr_code - first);
      if (r.command_index == CMD_IDX_PAUSE) begin
        paused = 1'b1;
      end else if (r.command_index == CMD_IDX_RESUME_A ||
                   r.command_index == CMD_IDX_RESUME_B) begin
        paused = 1'b0;
      end
    end else begin
      r.status = ST_UNKNOWN_CMD;
    end
    r.upload_paused = paused;
    expected_results.push_back(r);
    in_multi   = 1'b0;
    bytes_seen = 8'h00;
    xor_acc    = 8'h00;
  endtask

  // Advance the predictor by one accepted byte beat.
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    if (!in_multi) begin
      // clear the header at the first byte so that a short first fragment
      // leaves the missing header fields at zero
      if (bytes_seen == 8'h00) begin
        hdr_start  = 1'b0;
        hdr_seq    = 5'h00;
        hdr_length = 8'h00;
        hdr_code   = 8'h00;
      end
      if (bytes_seen == 8'(HEADER_POS)) begin
        hdr_start = |(b & START_BIT);
        hdr_seq   = 5'(b & SEQ_MASK);
      end
      if (bytes_seen == 8'(LENGTH_POS)) hdr_length = b;
      if (bytes_seen == 8'(COMMAND_POS)) hdr_code = b;
    end
    xor_acc ^= b;
    // the byte count saturates, so a long declared length may never close
    if (bytes_seen != 8'hFF) bytes_seen++;
    if (last) begin
      if (!in_multi && hdr_length >= shadow_cfg.single_fragment_limit) begin
        in_multi = 1'b1;
      end else if (!in_multi || bytes_seen > hdr_length) begin
        close_packet();
      end
    end
  endtask

  // Build one packet: header, length and code bytes, random body, and a last
  // byte that zeroes the XOR (flipped by one bit when spoil is set). Long
  // declared lengths get a first fragment end, maybe a middle one, and a
  // final one past the declared length.
  task automatic queue_packet(input logic [7:0] hdr, input logic [7:0] len,
                              input logic [7:0] code, input int total, input bit spoil);
    logic [7:0] pkt [$];
    bit         ends [$];
    logic [7:0] acc;
    logic [7:0] b;
    int         cut;
    int         top;
    acc = 8'h00;
    for (int i = 0; i < total; i++) begin
      if (i == HEADER_POS) b = hdr;
      else if (i == LENGTH_POS) b = len;
      else if (i == COMMAND_POS) b = code;
      else if (i == total - 1) b = acc;
      else b = 8'($urandom_range(0, 255));
      if (spoil && i == total - 1) b ^= 8'h01 << $urandom_range(0, 7);
      acc ^= b;
      pkt.push_back(b);
      ends.push_back(1'b0);
    end
    ends[total - 1] = 1'b1;
    if (len >= shadow_cfg.single_fragment_limit && total >= 4) begin
      cut = $urandom_range(3, total - 1);
      ends[cut - 1] = 1'b1;
      top = (len < total - 1) ? len : total - 1;
      if ($urandom_range(0, 1) == 1 && cut + 1 <= top) begin
        ends[$urandom_range(cut + 1, top) - 1] = 1'b1;
      end
    end
    for (int i = 0; i < total; i++) begin
      byte_beats.push_back('{data_byte: pkt[i], fragment_end: ends[i]});
    end
    beats_queued += total;
  endtask

  // Mostly well-formed packets with random content under the current
  // settings; the rest are spoiled checks, short packets and loose noise.
  task automatic queue_random_traffic(input int n);
    int         stop;
    int         k;
    int         total;
    int         hi;
    logic [7:0] lim;
    logic [7:0] hdr;
    logic [7:0] len;
    logic [7:0] code;
    stop = beats_queued + n;
    lim  = shadow_cfg.single_fragment_limit;
    while (beats_queued < stop) begin
      if ($urandom_range(0, 99) < 8) begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          byte_beats.push_back('{data_byte: 8'($urandom_range(0, 255)),
                                 fragment_end: ($urandom_range(0, 99) < 30)});
        end
        beats_queued += k;
      end else begin
        hdr = 8'($urandom_range(0, 255));
        hdr[7] = ($urandom_range(0, 99) < 85) ? shadow_cfg.host_start_mark[7]
                                               : ~shadow_cfg.host_start_mark[7];
        k = shadow_cfg.first_command_code + $urandom_range(0, 7);
        code = ($urandom_range(0, 99) < 80 && k <= 255) ? 8'(k) : 8'($urandom_range(0, 255));
        if (lim <= 8'd254 && (lim == 8'd0 || $urandom_range(0, 99) < 35)) begin
          hi    = (lim + 12 > 254) ? 254 : lim + 12;
          len   = 8'($urandom_range(lim, hi));
          total = len + 1 + $urandom_range(0, 3);
          if (total < 4) total = 4;
        end else begin
          len   = 8'($urandom_range(0, lim - 1));
          total = ($urandom_range(0, 99) < 92) ? $urandom_range(3, 10) : $urandom_range(1, 2);
        end
        queue_packet(hdr, len, code, total, $urandom_range(0, 99) < 10);
      end
    end
  endtask

  // Write one register; cfg_valid is left high so back-to-back writes
  // never lower and raise it in the same step.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SINGLE_LIMIT: shadow_cfg.single_fragment_limit = val;
      CFG_START_MARK:   shadow_cfg.host_start_mark = val;
      CFG_FIRST_CODE:   shadow_cfg.first_command_code = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [7:0] limit, input logic [7:0] mark,
                              input logic [7:0] first);
    write_reg(CFG_SINGLE_LIMIT, limit);
    write_reg(CFG_START_MARK, mark);
    write_reg(CFG_FIRST_CODE, first);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every queued beat to go in and every result to come out, then
  // give the block time to finish a trailing packet that yields no result.
  task automatic drain();
    while (byte_beats.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: hold a beat until it is taken, otherwise maybe idle, otherwise
  // offer the head of the queue. Inputs change only at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !beat_taken) begin
      // stalled: keep valid and payload steady
    end else if (byte_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      in_valid     <= 1'b1;
      data_byte    <= byte_beats[0].data_byte;
      fragment_end <= byte_beats[0].fragment_end;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: serve a long hold-off when one is requested, else stall at
  // the phase's odds.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor: sample handshakes at the rising edge, advance the predictor
  // on byte beats, check result beats, and watch for a hung block.
  always @(posedge clk) begin
    beat_taken   = !rst && in_valid && !in_stall;
    result_taken = !rst && out_valid && !out_stall;
    cfg_taken    = !rst && cfg_valid && cfg_ready;
    if (beat_taken) begin
      absorb_byte(data_byte, fragment_end);
      void'(byte_beats.pop_front());
    end
    if (result_taken) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat: status %0d code %0d seq %0d",
                                  status, command_code, sequence_number));
      end else begin
        oldest = expected_results.pop_front();
        check_field("status", status, oldest.status);
        check_field("command_index", command_index, oldest.command_index);
        check_field("command_code", command_code, oldest.command_code);
        check_field("sequence_number", sequence_number, oldest.sequence_number);
        check_field("upload_paused", upload_paused, oldest.upload_paused);
      end
    end
    if (rst || beat_taken || result_taken || cfg_taken) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[fragmented_packet_checker] ERROR");
      $finish;
    end
  end

  initial begin
    // hold reset, release on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed packets under reset settings: accept with resume and pause,
    // a length just under the single-fragment limit, all-ones header, a
    // lone header byte, a code just below the first one, a broken check.
    send_idle_pct = 23;
    recv_idle_pct = 62;
    queue_packet(8'h00, 8'd3, 8'd161, 4, 1'b0);
    queue_packet(8'h1F, 8'd16, 8'd164, 4, 1'b0);
    queue_packet(8'hFF, 8'd0, 8'hFF, 4, 1'b0);
    queue_packet(8'h00, 8'd0, 8'd0, 1, 1'b0);
    queue_packet(8'h0C, 8'd5, 8'd160, 4, 1'b0);
    queue_packet(8'h12, 8'd1, 8'd163, 4, 1'b1);
    queue_packet(8'h03, 8'd9, 8'd163, 4, 1'b0);
    drain();

    // Every packet spans fragments; set start mark, top of the code range.
    program_regs(8'd0, 8'd128, 8'd248);
    queue_packet(8'h83, 8'd0, 8'd255, 5, 1'b0);
    queue_packet(8'h9F, 8'd2, 8'd251, 4, 1'b0);
    queue_random_traffic(90);
    drain();

    // Swap idle odds. An odd start mark never matches, so every clean
    // packet is a header error; no packet spans fragments.
    send_idle_pct = 62;
    recv_idle_pct = 23;
    program_regs(8'd255, 8'd255, 8'd0);
    queue_random_traffic(60);
    drain();

    // First code above the usual range: only codes up to 255 are accepted.
    program_regs(8'd9, 8'd0, 8'd250);
    queue_random_traffic(60);
    drain();

    // No idling; stall the results for a long stretch while bytes keep
    // coming so that the block backs up onto its input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(8'd24, 8'd128, 8'd161);
    queue_random_traffic(100);
    @(posedge clk);
    hold_req = ~hold_req;
    drain();

    // Byte count saturation: a long single fragment, and a multi-fragment
    // packet that closes only once the count pins at 255.
    program_regs(8'd200, 8'd0, 8'd0);
    queue_packet(8'h00, 8'd10, 8'd0, 260, 1'b0);
    queue_packet(8'h07, 8'd254, 8'd3, 258, 1'b0);
    drain();

    if (mismatch_count == 0) begin
      $display("[fragmented_packet_checker] OK");
    end else begin
      $display("[fragmented_packet_checker] ERROR");
    end
    $finish;
  end

endmodule
